[sv/cbm_pkg.sv]
// ============================================================================
// cbm_pkg
// Shared types and codes for the cartridge bank mapper: transaction payloads,
// command and target codes, register decode regions and CHR bank memory size.
// ============================================================================
package cbm_pkg;

    // Request transaction payload
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    // Response transaction payload
    typedef struct packed {
        logic [2:0]  target;
        logic [17:0] mapped_address;
        logic        nametable_page;
    } rsp_t;

    // Commands
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_CPU_XL  = 2'd1;
    localparam logic [1:0] CMD_PPU_XL  = 2'd2;

    // Targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_NT_RAM  = 3'd4;

    // Register regions, CPU address bits 15:12
    localparam logic [3:0] RGN_PRG_FIRST  = 4'h8;
    localparam logic [3:0] RGN_MIRROR     = 4'h9;
    localparam logic [3:0] RGN_PRG_SECOND = 4'hA;
    localparam logic [3:0] RGN_CHR_FIRST  = 4'hB;
    localparam logic [3:0] RGN_CHR_LAST   = 4'hE;

    // CHR bank byte memory
    localparam int CHR_DEPTH = 8;
    localparam int CHR_IDX_W = $clog2(CHR_DEPTH);
    localparam int CHR_DATA_W = 8;

    // Write port of the CHR bank memory
    typedef struct packed {
        logic                  en;
        logic [CHR_IDX_W-1:0]  idx;
        logic [CHR_DATA_W-1:0] data;
    } chr_wr_t;

endpackage

[sv/cartridge_bank_mapper.sv]
// ============================================================================
// cartridge_bank_mapper
// Cartridge bank mapper: CPU register writes and CPU/PPU address translation.
// ============================================================================
// Usage:
//   req channel (req_valid / req_stall / req) carries, unless stalled, one
//   transaction per cycle: a CPU register write or a CPU/PPU address to map.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one response
//   per request, in order. A register write answers with target none.
//   Throughput: one transaction per clock unless rsp_stall holds. Requests
//   may follow each other back to back, including a CHR write followed by
//   a PPU fetch of the same bank; the bank memory forwards the fresh byte.
//   Pipeline: two register stages. Stage one reads the CHR bank byte
//   memory, stage two does the read-modify-write or the translation and
//   loads the output register.
//   Stall: when rsp_stall holds a response in the output register, the
//   request in stage one waits and req_stall rises; one more request is
//   still taken while stage one is empty. No transaction is lost.
//   Reset (rst_n low, asynchronous): pipeline empties, PRG banks go to 0
//   and 1, mirroring to vertical, CHR bank byte i to i via valid bits.
// ============================================================================
module cartridge_bank_mapper (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cbm_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cbm_pkg::rsp_t     rsp
);

    // ---------------------------------------------------------------- control
    logic          s1_valid_reg, s1_valid_next;
    cbm_pkg::req_t s1_req_reg,   s1_req_next;
    logic          out_valid_reg, out_valid_next;
    cbm_pkg::rsp_t rsp_reg,      rsp_next;
    logic          out_free;
    logic          advance;
    logic          accept;

    // ------------------------------------------------------------ bank state
    logic [3:0] prg_first_reg,  prg_first_next;
    logic [4:0] prg_second_reg, prg_second_next;
    logic [1:0] mirror_reg,     mirror_next;

    // -------------------------------------------------------- CHR memory port
    logic [cbm_pkg::CHR_IDX_W-1:0]  rd_idx;
    logic [cbm_pkg::CHR_DATA_W-1:0] chr_byte;
    cbm_pkg::chr_wr_t               chr_wr;
    logic [3:0]                     s0_pair;
    logic [3:0]                     s1_pair;
    logic [3:0]                     s1_region;
    logic [13:0]                    ppu_addr;
    logic                           nt_page;

    // Output register frees when empty or being taken; stage one moves then.
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign advance   = s1_valid_reg && out_free;
    assign req_stall = s1_valid_reg && !out_free;
    assign accept    = req_valid && !req_stall;

    assign rsp_valid = out_valid_reg;
    assign rsp       = rsp_reg;

    // Stage-zero read index: write picks byte pair plus A0, PPU uses A12:A10.
    assign s0_pair = req.address[15:12] - cbm_pkg::RGN_CHR_FIRST;

    always_comb
    begin
        if (req.command == cbm_pkg::CMD_WRITE)
        begin
            rd_idx = {s0_pair[1:0], req.address[0]};
        end
        else
        begin
            rd_idx = req.address[12:10];
        end
    end

    cbm_chr_mem u_chr_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (rd_idx),
        .wr      (chr_wr),
        .rd_data (chr_byte)
    );

    // ---------------------------------------------------------- stage two
    assign s1_region = s1_req_reg.address[15:12];
    assign s1_pair   = s1_region - cbm_pkg::RGN_CHR_FIRST;
    assign ppu_addr  = s1_req_reg.address[13:0];
    // horizontal mirroring follows A11, vertical follows A10
    assign nt_page   = mirror_reg[0] ? ppu_addr[11] : ppu_addr[10];

    always_comb
    begin
        prg_first_next  = prg_first_reg;
        prg_second_next = prg_second_reg;
        mirror_next     = mirror_reg;
        chr_wr.en       = 1'b0;
        chr_wr.idx      = {s1_pair[1:0], s1_req_reg.address[0]};
        // A1 selects high nibble
        if (s1_req_reg.address[1])
        begin
            chr_wr.data = {s1_req_reg.data[3:0], chr_byte[3:0]};
        end
        else
        begin
            chr_wr.data = {chr_byte[7:4], s1_req_reg.data[3:0]};
        end

        rsp_next.target         = cbm_pkg::TGT_NONE;
        rsp_next.mapped_address = '0;
        rsp_next.nametable_page = 1'b0;

        case (s1_req_reg.command)
            cbm_pkg::CMD_WRITE:
            begin
                if (advance)
                begin
                    unique case (s1_region) inside
                        cbm_pkg::RGN_PRG_FIRST:  prg_first_next  = s1_req_reg.data[3:0];
                        cbm_pkg::RGN_MIRROR:     mirror_next     = s1_req_reg.data[1:0];
                        cbm_pkg::RGN_PRG_SECOND: prg_second_next = s1_req_reg.data[4:0];
                        [cbm_pkg::RGN_CHR_FIRST:cbm_pkg::RGN_CHR_LAST]:
                            chr_wr.en = 1'b1;
                        default: ; // writes elsewhere are ignored
                    endcase
                end
            end
            cbm_pkg::CMD_CPU_XL:
            begin
                if (s1_req_reg.address[15:14] == 2'b11)
                begin
                    // fixed last 16K of a 128K window
                    rsp_next.target         = cbm_pkg::TGT_PRG_ROM;
                    rsp_next.mapped_address = {4'b0111, s1_req_reg.address[13:0]};
                end
                else if (s1_req_reg.address[15:13] == 3'b101)
                begin
                    rsp_next.target         = cbm_pkg::TGT_PRG_ROM;
                    rsp_next.mapped_address = {prg_second_reg, s1_req_reg.address[12:0]};
                end
                else if (s1_req_reg.address[15:13] == 3'b100)
                begin
                    rsp_next.target         = cbm_pkg::TGT_PRG_ROM;
                    rsp_next.mapped_address = {1'b0, prg_first_reg, s1_req_reg.address[12:0]};
                end
                else if (s1_req_reg.address[15:13] == 3'b011)
                begin
                    rsp_next.target         = cbm_pkg::TGT_PRG_RAM;
                    rsp_next.mapped_address = {5'b0, s1_req_reg.address[12:0]};
                end
            end
            cbm_pkg::CMD_PPU_XL:
            begin
                if (!ppu_addr[13])
                begin
                    // CHR byte drops its low bit
                    rsp_next.target         = cbm_pkg::TGT_CHR_ROM;
                    rsp_next.mapped_address = {1'b0, chr_byte[7:1], ppu_addr[9:0]};
                end
                else
                begin
                    rsp_next.target         = cbm_pkg::TGT_NT_RAM;
                    rsp_next.mapped_address = {7'b0, nt_page, ppu_addr[9:0]};
                    rsp_next.nametable_page = nt_page;
                end
            end
            default: ; // unused command: response stays none
        endcase
    end

    // ------------------------------------------------------ pipeline control
    always_comb
    begin
        s1_req_next = accept ? req : s1_req_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s1_req_reg <= s1_req_next;
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prg_first_reg  <= 4'd0;
            prg_second_reg <= 5'd1;
            mirror_reg     <= 2'd0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            prg_first_reg  <= prg_first_next;
            prg_second_reg <= prg_second_next;
            mirror_reg     <= mirror_next;
        end
    end

endmodule

[sv/cbm_chr_mem.sv]
// ============================================================================
// cbm_chr_mem
// CHR bank byte store: synchronous memory with a registered read,
// per-entry valid bits for the reset contents and same-edge write forwarding.
// ============================================================================
module cbm_chr_mem (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   rd_en,
    input  logic [cbm_pkg::CHR_IDX_W-1:0]          rd_idx,
    input  cbm_pkg::chr_wr_t                       wr,
    output logic [cbm_pkg::CHR_DATA_W-1:0]         rd_data
);

    logic [cbm_pkg::CHR_DATA_W-1:0] mem [cbm_pkg::CHR_DEPTH];
    logic [cbm_pkg::CHR_DATA_W-1:0] rd_q_reg;
    logic [cbm_pkg::CHR_DEPTH-1:0]  valid_reg;
    logic [cbm_pkg::CHR_DEPTH-1:0]  valid_next;
    logic                           rd_valid_reg;
    logic [cbm_pkg::CHR_IDX_W-1:0]  rd_idx_reg;
    logic                           fwd_hit_reg;
    logic [cbm_pkg::CHR_DATA_W-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg     <= mem[rd_idx];
            fwd_data_reg <= wr.data;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (wr.en)
        begin
            valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg   <= '0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
                rd_idx_reg   <= rd_idx;
                // write landing on the entry being read at the same edge
                fwd_hit_reg  <= wr.en && (wr.idx == rd_idx);
            end
        end
    end

    // never-written entries read as their index
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            rd_data = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            rd_data = rd_q_reg;
        end
        else
        begin
            rd_data = {{(cbm_pkg::CHR_DATA_W-cbm_pkg::CHR_IDX_W){1'b0}}, rd_idx_reg};
        end
    end

endmodule
